// ===== hw/rtl/dip_pkg.sv =====
// Package for the decimal integer parser: phase and status codes, character
// constants, configuration indexes and the magnitude limit function.
// No dependencies.
package dip_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int LEN_BITS       = 16;
	localparam int VALUE_BITS     = 64;
	localparam int CFG_IDX_BITS   = 1;
	localparam int CFG_DATA_BITS  = 2;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_BITS-1:0] CFG_SIGNED_MODE  = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH_SELECT = 1'b1;

	localparam logic       SIGNED_MODE_RST  = 1'b1;
	localparam logic [1:0] WIDTH_SELECT_RST = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NAN       = 2'd1;
	localparam logic [1:0] ST_MINUS_ERR = 2'd2;
	localparam logic [1:0] ST_RANGE     = 2'd3;

	// ASCII characters that the parser looks for.
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [1:0] {
		PH_START,
		PH_SIGN,
		PH_DIGITS
	} phase_t;

	// Controls that the accumulator needs from the parser state and config.
	typedef struct packed {
		logic       negative;
		logic       overflowed;
		logic       signed_mode;
		logic [1:0] width_select;
	} acc_ctl_t;

	// Flags that come back from the accumulator.
	typedef struct packed {
		logic overflowed;
		logic over_limit;
	} acc_flags_t;

	// Largest magnitude allowed for the configured width and signedness.
	function automatic logic [VALUE_BITS-1:0] mag_limit(
		input logic [1:0] width_select,
		input logic       signed_mode,
		input logic       negative
	);
		logic [5:0]            top_bit;
		logic [VALUE_BITS-1:0] half;
		logic [VALUE_BITS-1:0] lim;
		top_bit = (6'd8 << width_select) - 6'd1;
		half    = {{(VALUE_BITS-1){1'b0}}, 1'b1} << top_bit;
		if (!signed_mode && !negative) begin
			lim = (half << 1) - {{(VALUE_BITS-1){1'b0}}, 1'b1};
		end else if (negative) begin
			lim = half;
		end else begin
			lim = half - {{(VALUE_BITS-1){1'b0}}, 1'b1};
		end
		return lim;
	endfunction

endpackage

// ===== hw/rtl/dip_accum.sv =====
// Decimal accumulator: multiply by ten, add a digit and check the range.
// Depends on dip_pkg.
module dip_accum (
	input  logic [dip_pkg::VALUE_BITS-1:0] magnitude,
	input  logic [3:0]                     digit,
	input  dip_pkg::acc_ctl_t              ctl,
	output logic [dip_pkg::VALUE_BITS-1:0] magnitude_next,
	output dip_pkg::acc_flags_t            flags
);

	localparam int WideBits = dip_pkg::VALUE_BITS + 4;

	logic [dip_pkg::VALUE_BITS-1:0] limit;
	logic [WideBits-1:0]            wide;
	logic                           digit_ovf;

	assign limit = dip_pkg::mag_limit(ctl.width_select, ctl.signed_mode, ctl.negative);

	// Ten times the magnitude is eight times plus two times; the exact sum
	// exceeds the limit exactly when the new digit would overflow.
	assign wide = {1'b0, magnitude, 3'b000}
		+ {3'b000, magnitude, 1'b0}
		+ {{(WideBits-4){1'b0}}, digit};
	assign digit_ovf = wide > {4'b0000, limit};

	assign magnitude_next   = (ctl.overflowed || digit_ovf) ? magnitude
		: wide[dip_pkg::VALUE_BITS-1:0];
	assign flags.overflowed = ctl.overflowed || digit_ovf;
	assign flags.over_limit = magnitude > limit;

endmodule

// ===== hw/rtl/decimal_integer_parser.sv =====
// Top level of the streaming ASCII decimal integer parser.
// Depends on dip_pkg and dip_accum.
//
// Usage: text bytes enter on the char_byte channel (in_valid/in_ready), one
// byte per transaction. A number is an optional '+' or '-' followed by one or
// more digits; it ends at the first non-digit byte, which is reported in
// end_byte and dropped. Each finished number, and each error, produces one
// transaction on the result channel (out_valid/out_ready) carrying status,
// value_bits, length_used and end_byte. Digits and accepted signs give nothing.
// Configuration (signed_mode at index 0, width_select at index 1) is written
// through cfg_valid/cfg_ready, which is always ready; write it only while the
// parser is idle.
// An accepted byte waits in the input register; when it advances, any result
// it produces is loaded into the output register, which drives out_valid.
// The parser takes one byte per cycle while the result channel does not
// stall: the input register is refilled in the same cycle it hands its byte
// to the parse logic, and the range check is one wide add and compare.
// When the receiver stalls with a result pending, the input register holds its
// byte and in_ready drops once that register is full. Reset returns the parser
// to the start of a number, empties both registers and restores signed mode
// with a 64-bit target width.
module decimal_integer_parser #(
	parameter int COUNT_BITS = dip_pkg::COUNT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [dip_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [dip_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        char_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        status,
	output logic [dip_pkg::VALUE_BITS-1:0]    value_bits,
	output logic [dip_pkg::LEN_BITS-1:0]      length_used,
	output logic [7:0]                        end_byte
);

	localparam int VB = dip_pkg::VALUE_BITS;
	localparam int LB = dip_pkg::LEN_BITS;

	// Configuration registers.
	logic       signed_mode_q;
	logic [1:0] width_select_q;

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Parser state.
	dip_pkg::phase_t       phase_q, phase_d;
	logic                  negative_q, negative_d;
	logic [VB-1:0]         mag_q, mag_d;
	logic                  ovf_q, ovf_d;
	logic [COUNT_BITS-1:0] count_q, count_d, count_inc;

	// Output register.
	logic          out_valid_q;
	logic [1:0]    status_q;
	logic [VB-1:0] value_q;
	logic [LB-1:0] length_q;
	logic [7:0]    end_byte_q;

	logic                  advance;
	logic                  is_digit;
	logic                  emit;
	logic [1:0]            st_d;
	logic [VB-1:0]         val_d;
	logic [COUNT_BITS-1:0] len_cnt;
	logic [LB-1:0]         len_sat;

	dip_pkg::acc_ctl_t   acc_ctl;
	dip_pkg::acc_flags_t acc_flags;
	logic [VB-1:0]       mag_next;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_mode_q  <= dip_pkg::SIGNED_MODE_RST;
			width_select_q <= dip_pkg::WIDTH_SELECT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				dip_pkg::CFG_SIGNED_MODE:  signed_mode_q  <= cfg_data[0];
				dip_pkg::CFG_WIDTH_SELECT: width_select_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The byte in the input register is processed when the output register
	// is free or is being emptied in this cycle.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= char_byte;
		end
	end

	assign is_digit  = byte_s1 inside {[dip_pkg::CH_ZERO:dip_pkg::CH_NINE]};
	assign count_inc = (&count_q) ? count_q : count_q + COUNT_BITS'(1);

	assign acc_ctl.negative     = negative_q;
	assign acc_ctl.overflowed   = ovf_q;
	assign acc_ctl.signed_mode  = signed_mode_q;
	assign acc_ctl.width_select = width_select_q;

	dip_accum u_accum (
		.magnitude      (mag_q),
		.digit          (byte_s1[3:0]),
		.ctl            (acc_ctl),
		.magnitude_next (mag_next),
		.flags          (acc_flags)
	);

	// Next state and result for the byte in the input register.
	always_comb begin
		phase_d    = phase_q;
		negative_d = negative_q;
		mag_d      = mag_q;
		ovf_d      = ovf_q;
		count_d    = count_q;
		emit       = 1'b0;
		st_d       = dip_pkg::ST_OK;
		val_d      = '0;
		len_cnt    = '0;
		case (phase_q)
			dip_pkg::PH_START: begin
				if (byte_s1 == dip_pkg::CH_MINUS) begin
					if (!signed_mode_q) begin
						// Minus in unsigned mode is dropped and the parser stays here.
						emit = 1'b1;
						st_d = dip_pkg::ST_MINUS_ERR;
					end else begin
						negative_d = 1'b1;
						count_d    = COUNT_BITS'(1);
						phase_d    = dip_pkg::PH_SIGN;
					end
				end else if (byte_s1 == dip_pkg::CH_PLUS) begin
					count_d = COUNT_BITS'(1);
					phase_d = dip_pkg::PH_SIGN;
				end else if (is_digit) begin
					mag_d   = mag_next;
					ovf_d   = acc_flags.overflowed;
					count_d = count_inc;
					phase_d = dip_pkg::PH_DIGITS;
				end else begin
					emit = 1'b1;
					st_d = dip_pkg::ST_NAN;
				end
			end
			dip_pkg::PH_SIGN: begin
				if (is_digit) begin
					mag_d   = mag_next;
					ovf_d   = acc_flags.overflowed;
					count_d = count_inc;
					phase_d = dip_pkg::PH_DIGITS;
				end else begin
					// A sign with no digit after it is not a number.
					emit       = 1'b1;
					st_d       = dip_pkg::ST_NAN;
					phase_d    = dip_pkg::PH_START;
					negative_d = 1'b0;
					mag_d      = '0;
					ovf_d      = 1'b0;
					count_d    = '0;
				end
			end
			dip_pkg::PH_DIGITS: begin
				if (is_digit) begin
					mag_d   = mag_next;
					ovf_d   = acc_flags.overflowed;
					count_d = count_inc;
				end else begin
					// The number ends here; the magnitude is checked once more
					// against the configuration of this moment.
					emit = 1'b1;
					if (negative_q && !signed_mode_q) begin
						st_d = dip_pkg::ST_MINUS_ERR;
					end else if (ovf_q || acc_flags.over_limit) begin
						st_d = dip_pkg::ST_RANGE;
					end else begin
						val_d   = negative_q ? (VB'(0) - mag_q) : mag_q;
						len_cnt = count_q;
					end
					phase_d    = dip_pkg::PH_START;
					negative_d = 1'b0;
					mag_d      = '0;
					ovf_d      = 1'b0;
					count_d    = '0;
				end
			end
			default: begin
				phase_d    = dip_pkg::PH_START;
				negative_d = 1'b0;
				mag_d      = '0;
				ovf_d      = 1'b0;
				count_d    = '0;
			end
		endcase
	end

	// The reported length saturates at the width of the length field.
	generate
		if (COUNT_BITS > LB) begin : g_len_sat
			assign len_sat = (|len_cnt[COUNT_BITS-1:LB]) ? {LB{1'b1}} : len_cnt[LB-1:0];
		end else begin : g_len_ext
			assign len_sat = LB'(len_cnt);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dip_pkg::PH_START;
		end else if (advance) begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			negative_q <= 1'b0;
			mag_q      <= '0;
			ovf_q      <= 1'b0;
			count_q    <= '0;
		end else if (advance) begin
			negative_q <= negative_d;
			mag_q      <= mag_d;
			ovf_q      <= ovf_d;
			count_q    <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			status_q   <= st_d;
			value_q    <= val_d;
			length_q   <= len_sat;
			end_byte_q <= byte_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign value_bits  = value_q;
	assign length_used = length_q;
	assign end_byte    = end_byte_q;

endmodule
